FILE: rtl/activity_request_header_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the activity request header checker
// Concurrent assertion wrappers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef ACTIVITY_REQUEST_HEADER_CHECKER_UNIT_MACROS_SVH
`define ACTIVITY_REQUEST_HEADER_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ARHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ARHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ARHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/arhc_pkg.sv
// ----------------------------------------------------------------------------
// arhc_pkg
// Types, codes and reset constants shared by the header checker modules.
// ----------------------------------------------------------------------------
package arhc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_W         = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_FORM_CODE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPACT_FORM_CODE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_BYTES = 8'd2;

    localparam logic [7:0]  FULL_FORM_CODE_RESET    = 8'd1;
    localparam logic [7:0]  COMPACT_FORM_CODE_RESET = 8'd2;
    localparam logic [31:0] MAX_PAYLOAD_BYTES_RESET = 32'd65535;

    // Header layout.
    localparam logic [4:0] SESSION_END      = 5'd8;
    localparam logic [4:0] FORM_POS         = 5'd8;
    localparam logic [4:0] TYPE_END         = 5'd13;
    localparam logic [4:0] LENGTH_END       = 5'd17;
    localparam logic [4:0] MASK_END         = 5'd21;
    localparam logic [4:0] COMPACT_OFFSET   = 5'd17;
    localparam logic [4:0] FULL_OFFSET      = 5'd21;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_FORM  = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_MISMATCH  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  status;
        logic [63:0] session_id;
        logic [31:0] message_type;
        logic [31:0] peer_mask;
        logic        has_mask;
        logic [31:0] payload_length;
        logic [4:0]  payload_offset;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  full_form_code;
        logic [7:0]  compact_form_code;
        logic [31:0] max_payload_bytes;
    } cfg_t;

    // Header view after the byte in the capture stage has been taken in.
    typedef struct packed {
        logic        valid;
        logic        eof;
        logic [63:0] session;
        logic [7:0]  form;
        logic [31:0] mtype;
        logic [31:0] plen;
        logic [31:0] mask;
    } frame_t;

endpackage

FILE: rtl/arhc_cfg.sv
// ----------------------------------------------------------------------------
// arhc_cfg
// Configuration register file of the header checker.
// ----------------------------------------------------------------------------
module arhc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data,
    output arhc_pkg::cfg_t                      cfg
);

    arhc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_form_code    <= arhc_pkg::FULL_FORM_CODE_RESET;
            cfg_reg.compact_form_code <= arhc_pkg::COMPACT_FORM_CODE_RESET;
            cfg_reg.max_payload_bytes <= arhc_pkg::MAX_PAYLOAD_BYTES_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                arhc_pkg::CFG_FULL_FORM_CODE:    cfg_reg.full_form_code    <= cfg_data[7:0];
                arhc_pkg::CFG_COMPACT_FORM_CODE: cfg_reg.compact_form_code <= cfg_data[7:0];
                arhc_pkg::CFG_MAX_PAYLOAD_BYTES: cfg_reg.max_payload_bytes <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/arhc_capture.sv
// ----------------------------------------------------------------------------
// arhc_capture
// Input register, byte counter and header field capture.
// ----------------------------------------------------------------------------
module arhc_capture #(
    parameter int COUNT_WIDTH = arhc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  arhc_pkg::in_item_t      s_data,
    input  logic                    slot_free,
    output arhc_pkg::frame_t        frame,
    output logic [COUNT_WIDTH-1:0]  frame_len
);

    logic                   in_valid_reg;
    arhc_pkg::in_item_t     in_data_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [63:0]            session_reg;
    logic [63:0]            session_next;
    logic [7:0]             form_reg;
    logic [7:0]             form_next;
    logic [31:0]            type_reg;
    logic [31:0]            type_next;
    logic [31:0]            length_reg;
    logic [31:0]            length_next;
    logic [31:0]            mask_reg;
    logic [31:0]            mask_next;
    logic                   fire;
    logic [7:0]             b;

    assign b = in_data_reg.data_byte;

    // A last byte only moves on when the result register can take its verdict.
    assign fire    = in_valid_reg && (!in_data_reg.end_of_frame || slot_free);
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        session_next = session_reg;
        form_next    = form_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        mask_next    = mask_reg;
        priority if (count_reg < COUNT_WIDTH'(arhc_pkg::SESSION_END)) begin
            session_next = {session_reg[55:0], b};
        end else if (count_reg == COUNT_WIDTH'(arhc_pkg::FORM_POS)) begin
            form_next = b;
        end else if (count_reg < COUNT_WIDTH'(arhc_pkg::TYPE_END)) begin
            type_next = {type_reg[23:0], b};
        end else if (count_reg < COUNT_WIDTH'(arhc_pkg::LENGTH_END)) begin
            length_next = {length_reg[23:0], b};
        end else if (count_reg < COUNT_WIDTH'(arhc_pkg::MASK_END)) begin
            mask_next = {mask_reg[23:0], b};
        end else begin
            // Bytes past the header are only counted.
        end
        // The count sticks at its maximum on very long frames.
        count_next = (&count_reg) ? count_reg : count_reg + COUNT_WIDTH'(1);
    end

    assign frame.valid   = fire;
    assign frame.eof     = in_data_reg.end_of_frame;
    assign frame.session = session_next;
    assign frame.form    = form_next;
    assign frame.mtype   = type_next;
    assign frame.plen    = length_next;
    assign frame.mask    = mask_next;
    assign frame_len     = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            session_reg <= '0;
            form_reg    <= '0;
            type_reg    <= '0;
            length_reg  <= '0;
            mask_reg    <= '0;
        end else if (fire) begin
            if (in_data_reg.end_of_frame) begin
                count_reg   <= '0;
                session_reg <= '0;
                form_reg    <= '0;
                type_reg    <= '0;
                length_reg  <= '0;
                mask_reg    <= '0;
            end else begin
                count_reg   <= count_next;
                session_reg <= session_next;
                form_reg    <= form_next;
                type_reg    <= type_next;
                length_reg  <= length_next;
                mask_reg    <= mask_next;
            end
        end
    end

endmodule

FILE: rtl/arhc_verdict.sv
// ----------------------------------------------------------------------------
// arhc_verdict
// Header checks at frame end and the result register.
// ----------------------------------------------------------------------------
module arhc_verdict #(
    parameter int COUNT_WIDTH = arhc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  arhc_pkg::frame_t        frame,
    input  logic [COUNT_WIDTH-1:0]  frame_len,
    input  arhc_pkg::cfg_t          cfg,
    output logic                    slot_free,
    output logic                    m_valid,
    input  logic                    m_ready,
    output arhc_pkg::out_item_t     m_data
);

    localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic                   m_valid_reg;
    arhc_pkg::out_item_t    m_data_reg;
    arhc_pkg::out_item_t    m_data_next;
    arhc_pkg::status_t      status;
    logic                   full;
    logic [4:0]             offset;
    logic [CMP_W-1:0]       len_ext;
    logic [CMP_W-1:0]       body_len;

    assign full     = frame.form == cfg.full_form_code;
    assign offset   = full ? arhc_pkg::FULL_OFFSET : arhc_pkg::COMPACT_OFFSET;
    assign len_ext  = CMP_W'(frame_len);
    assign body_len = len_ext - CMP_W'(offset);

    always_comb begin
        priority if (frame_len < COUNT_WIDTH'(arhc_pkg::COMPACT_OFFSET)) begin
            status = arhc_pkg::ST_TOO_SHORT;
        end else if (!full && frame.form != cfg.compact_form_code) begin
            status = arhc_pkg::ST_BAD_FORM;
        end else if (frame_len < COUNT_WIDTH'(offset)) begin
            status = arhc_pkg::ST_TOO_SHORT;
        end else if (frame.plen > cfg.max_payload_bytes) begin
            status = arhc_pkg::ST_TOO_LONG;
        end else if (CMP_W'(frame.plen) != body_len) begin
            status = arhc_pkg::ST_MISMATCH;
        end else begin
            status = arhc_pkg::ST_OK;
        end

        m_data_next        = '0;
        m_data_next.status = status;
        if (status == arhc_pkg::ST_OK) begin
            m_data_next.accepted       = 1'b1;
            m_data_next.session_id     = frame.session;
            m_data_next.message_type   = frame.mtype;
            m_data_next.peer_mask      = full ? frame.mask : 32'd0;
            m_data_next.has_mask       = full;
            m_data_next.payload_length = frame.plen;
            m_data_next.payload_offset = offset;
        end
    end

    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (slot_free) begin
            m_valid_reg <= frame.valid && frame.eof;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && frame.valid && frame.eof) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: rtl/activity_request_header_checker_unit.sv
// ----------------------------------------------------------------------------
// activity_request_header_checker_unit
// Byte-stream request header checker: one verdict per frame.
// ----------------------------------------------------------------------------
// Usage: request bytes enter on the s_ channel, one byte per transfer, with
// end_of_frame set on the last byte. Each frame yields exactly one transfer on
// the m_ channel, carrying the verdict, a status code and the decoded header
// fields (zero when the frame is rejected). Payload bytes are only counted.
// The cfg_ channel writes the form codes and the payload length limit; it is
// always ready, and writes to unknown indexes are dropped. Write it only while
// no frame is in flight.
// Path of a verdict: the last byte passes the input register, and its verdict
// is then registered in the result register once that one is free.
// Throughput: one byte per cycle while m_ready keeps the result register free,
// set by the single capture register stage, even for back-to-back one-byte frames.
// Reset (synchronous, active low) empties both register stages, clears the
// byte counter and the captured header, and restores the reset configuration.
// Stall: while a verdict waits on m_ready, non-final bytes keep flowing in;
// the next final byte holds in the input register until the result register
// frees, and s_ready is low while it waits.
// ----------------------------------------------------------------------------
`include "activity_request_header_checker_unit_macros.svh"

module activity_request_header_checker_unit #(
    parameter int COUNT_WIDTH = arhc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request byte stream.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  arhc_pkg::in_item_t                  s_data,
    // Verdict stream.
    output logic                                m_valid,
    input  logic                                m_ready,
    output arhc_pkg::out_item_t                 m_data,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data
);

    arhc_pkg::cfg_t         cfg;
    arhc_pkg::frame_t       frame;
    logic [COUNT_WIDTH-1:0] frame_len;
    logic                   slot_free;

    // Configuration registers.
    arhc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and header capture; presents the header as it stands
    // after the current byte, together with the saturated frame length.
    arhc_capture #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .slot_free (slot_free),
        .frame     (frame),
        .frame_len (frame_len)
    );

    // Checks on the final byte and the result register.
    arhc_verdict #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_verdict (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frame     (frame),
        .frame_len (frame_len),
        .cfg       (cfg),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A final byte that leaves the capture stage always lands a verdict.
    `ARHC_ASSERT_NEXT(a_eof_gives_verdict, aclk, aresetn, frame.valid && frame.eof, m_valid, "final byte did not produce a verdict")
    // A final byte may only leave the capture stage into a free result slot.
    `ARHC_ASSERT_NOW(a_eof_needs_slot, aclk, aresetn, frame.valid && frame.eof, slot_free, "final byte moved while the result register was full")
    // After a final byte the next frame starts from byte zero.
    `ARHC_ASSERT_NEXT(a_eof_restarts_count, aclk, aresetn, frame.valid && frame.eof, u_capture.count_reg == '0, "byte counter not cleared at frame end")
    // An accepted full-form verdict always reports the long header offset.
    `ARHC_ASSERT_NOW(a_mask_offset, aclk, aresetn, m_valid && m_data.has_mask, m_data.payload_offset == arhc_pkg::FULL_OFFSET, "mask present with compact offset")

endmodule

FILE: bench/tb_activity_request_header_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_activity_request_header_checker_unit
// Self-checking bench for the request header checker. Frames are built as
// byte streams and fed through the s_ channel with random gaps. An internal
// header decoder predicts each verdict, and the m_ channel output is compared
// with it field by field while the receiver stalls at random. The form codes
// and the length limit are rewritten between phases, always at frame
// boundaries with nothing in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_activity_request_header_checker_unit;

    localparam int RESET_CYCLES  = 12;
    // A verdict leaves through the input and result registers after the last byte,
    // so this margin is plenty to be sure that nothing is still inside the block.
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT_NS  = 400_000;
    // Indexes at or above this one do not address any register.
    localparam logic [arhc_pkg::CFG_INDEX_W-1:0] CFG_REG_COUNT = 8'd3;
    localparam longint unsigned COUNT_LIMIT = {arhc_pkg::COUNT_WIDTH_DEFAULT{1'b1}};

    typedef logic [arhc_pkg::CFG_INDEX_W-1:0] cfg_index_t;

    // Shapes of frame that the generator can build.
    typedef enum int {
        FR_COMPACT_OK,
        FR_FULL_OK,
        FR_SHORT,
        FR_FULL_SHORT,
        FR_BAD_FORM,
        FR_TOO_LONG,
        FR_MISMATCH,
        FR_NOISE
    } frame_kind_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    arhc_pkg::in_item_t   s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    arhc_pkg::out_item_t  m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Bytes waiting to be driven, and verdicts predicted but not yet seen.
    arhc_pkg::in_item_t  request_bytes[$];
    arhc_pkg::out_item_t pending_verdicts[$];

    // Register values as the block should currently hold them.
    arhc_pkg::cfg_t active_cfg;

    // Header capture of the decoder, mirroring the frame in progress.
    longint unsigned seen_bytes;
    logic [63:0] cap_session;
    logic [7:0]  cap_form;
    logic [31:0] cap_type;
    logic [31:0] cap_length;
    logic [31:0] cap_mask;

    int mismatches    = 0;
    int verdict_count = 0;
    int queued_bytes  = 0;

    // Idling controls, in percent per decision, changed between phases.
    int feed_idle_pct = 0;
    int stall_pct     = 0;
    int feed_gap      = 0;
    int hold_left     = 0;

    activity_request_header_checker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Takes one accepted byte into the header capture. On the last byte of a
    // frame it judges the frame, queues the verdict and starts a new capture.
    function automatic void predict_verdict(input arhc_pkg::in_item_t item);
        longint unsigned     pos;
        longint unsigned     frame_len;
        logic                full;
        logic [4:0]          offset;
        arhc_pkg::status_t   code;
        arhc_pkg::out_item_t verdict;
        pos = seen_bytes;
        if (pos < arhc_pkg::SESSION_END) begin
            cap_session = {cap_session[55:0], item.data_byte};
        end else if (pos == arhc_pkg::FORM_POS) begin
            cap_form = item.data_byte;
        end else if (pos < arhc_pkg::TYPE_END) begin
            cap_type = {cap_type[23:0], item.data_byte};
        end else if (pos < arhc_pkg::LENGTH_END) begin
            cap_length = {cap_length[23:0], item.data_byte};
        end else if (pos < arhc_pkg::MASK_END) begin
            cap_mask = {cap_mask[23:0], item.data_byte};
        end
        // The byte counter saturates, and so does the frame length taken from it.
        frame_len = (pos >= COUNT_LIMIT) ? COUNT_LIMIT : pos + 1;
        if (!item.end_of_frame) begin
            seen_bytes = frame_len;
            return;
        end
        // Checks run in a fixed order: the compact header length first, then
        // the form code, the full header length, the limit and the match.
        full   = 1'b0;
        offset = arhc_pkg::COMPACT_OFFSET;
        if (frame_len < arhc_pkg::COMPACT_OFFSET) begin
            code = arhc_pkg::ST_TOO_SHORT;
        end else begin
            // When both codes are equal, the full form takes precedence.
            full = (cap_form == active_cfg.full_form_code);
            if (!full && cap_form != active_cfg.compact_form_code) begin
                code = arhc_pkg::ST_BAD_FORM;
            end else begin
                offset = full ? arhc_pkg::FULL_OFFSET : arhc_pkg::COMPACT_OFFSET;
                if (frame_len < offset) begin
                    code = arhc_pkg::ST_TOO_SHORT;
                end else if (cap_length > active_cfg.max_payload_bytes) begin
                    code = arhc_pkg::ST_TOO_LONG;
                end else if (cap_length != frame_len - offset) begin
                    code = arhc_pkg::ST_MISMATCH;
                end else begin
                    code = arhc_pkg::ST_OK;
                end
            end
        end
        verdict = '0;
        verdict.status = code;
        if (code == arhc_pkg::ST_OK) begin
            verdict.accepted       = 1'b1;
            verdict.session_id     = cap_session;
            verdict.message_type   = cap_type;
            verdict.peer_mask      = full ? cap_mask : 32'd0;
            verdict.has_mask       = full;
            verdict.payload_length = cap_length;
            verdict.payload_offset = offset;
        end
        pending_verdicts.push_back(verdict);
        seen_bytes  = 0;
        cap_session = '0;
        cap_form    = '0;
        cap_type    = '0;
        cap_length  = '0;
        cap_mask    = '0;
    endfunction

    // Builds one frame of the given shape against the current registers and
    // appends its bytes to the send queue, the last one marked as frame end.
    task automatic queue_frame(input frame_kind_t kind);
        logic [63:0]        session;
        logic [7:0]         form;
        logic [31:0]        mtype;
        logic [31:0]        plen;
        logic [31:0]        mask;
        logic [167:0]       header;
        logic               full;
        arhc_pkg::in_item_t item;
        int                 pay;
        int                 head_len;
        int                 keep;
        int                 k;
        case ($urandom_range(0, 7))
            0:       session = '0;
            1:       session = '1;
            default: session = {$urandom, $urandom};
        endcase
        mtype = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
        mask  = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
        // Most payloads are tiny so that many frames fit in the run.
        pay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 6);

        if (kind == FR_FULL_OK || kind == FR_FULL_SHORT) begin
            full = 1'b1;
        end else if (kind == FR_COMPACT_OK || kind == FR_SHORT) begin
            full = 1'b0;
        end else begin
            full = 1'($urandom_range(0, 1));
        end
        form = full ? active_cfg.full_form_code : active_cfg.compact_form_code;

        case (kind)
            FR_COMPACT_OK, FR_FULL_OK: begin
                if (pay > active_cfg.max_payload_bytes) begin
                    pay = active_cfg.max_payload_bytes;
                end
                plen = pay;
            end
            FR_BAD_FORM: begin
                do begin
                    form = 8'($urandom_range(0, 255));
                end while (form == active_cfg.full_form_code ||
                           form == active_cfg.compact_form_code);
                plen = pay;
            end
            FR_TOO_LONG: begin
                if (active_cfg.max_payload_bytes == 32'hFFFF_FFFF) begin
                    // Nothing lies above this limit; it becomes a mismatch.
                    plen = pay + 1;
                end else if ($urandom_range(0, 1) || active_cfg.max_payload_bytes[31]) begin
                    plen = active_cfg.max_payload_bytes + 1;
                end else begin
                    do begin
                        plen = $urandom;
                    end while (plen <= active_cfg.max_payload_bytes);
                end
            end
            FR_MISMATCH: begin
                case ($urandom_range(0, 2))
                    0: plen = pay + 1;
                    1: plen = (pay == 0) ? 32'hFFFF_FFFF : pay - 1;
                    default: begin
                        plen = $urandom;
                        if (plen == pay) plen++;
                    end
                endcase
            end
            default: plen = pay;
        endcase

        header   = {session, form, mtype, plen, mask};
        head_len = full ? arhc_pkg::FULL_OFFSET : arhc_pkg::COMPACT_OFFSET;
        case (kind)
            FR_SHORT:      keep = $urandom_range(1, 16);
            FR_FULL_SHORT: keep = $urandom_range(17, 20);
            FR_NOISE:      keep = $urandom_range(1, 30);
            default:       keep = head_len + pay;
        endcase

        for (k = 0; k < keep; k++) begin
            if (kind != FR_NOISE && k < head_len) begin
                item.data_byte = header[167 - 8 * k -: 8];
            end else begin
                item.data_byte = 8'($urandom_range(0, 255));
            end
            item.end_of_frame = (k == keep - 1);
            request_bytes.push_back(item);
        end
        queued_bytes += keep;
    endtask

    // Returns once every byte has been taken, every verdict has arrived and
    // the block has had time to drain its register stages.
    task automatic wait_for_idle();
        do begin
            @(posedge aclk);
        end while (request_bytes.size() != 0 || s_valid || pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One write on the configuration channel. The decoder takes the new value
    // at the same edge as the block does; unknown indexes change nothing.
    task automatic write_register(input cfg_index_t index,
                                  input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            arhc_pkg::CFG_FULL_FORM_CODE:
                active_cfg.full_form_code = value[7:0];
            arhc_pkg::CFG_COMPACT_FORM_CODE:
                active_cfg.compact_form_code = value[7:0];
            arhc_pkg::CFG_MAX_PAYLOAD_BYTES:
                active_cfg.max_payload_bytes = value;
            default: ;
        endcase
    endtask

    // Rewrites all three registers, and also sends one write to an index that
    // does not exist, which the block must drop.
    task automatic apply_config(input arhc_pkg::cfg_t next_cfg);
        write_register(arhc_pkg::CFG_FULL_FORM_CODE, {24'd0, next_cfg.full_form_code});
        write_register(arhc_pkg::CFG_COMPACT_FORM_CODE, {24'd0, next_cfg.compact_form_code});
        write_register(arhc_pkg::CFG_MAX_PAYLOAD_BYTES, next_cfg.max_payload_bytes);
        write_register(cfg_index_t'($urandom_range(CFG_REG_COUNT, 255)), $urandom);
    endtask

    // Queues random frames until the byte budget is spent, then drains.
    // Well-formed frames dominate so that most traffic reaches the length
    // checks; the rest is truncated, misdeclared or plain noise.
    task automatic run_frames(input int byte_budget);
        int start_bytes;
        int roll;
        start_bytes = queued_bytes;
        while (queued_bytes - start_bytes < byte_budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                queue_frame(FR_COMPACT_OK);
            end else if (roll < 55) begin
                queue_frame(FR_FULL_OK);
            end else if (roll < 63) begin
                queue_frame(FR_SHORT);
            end else if (roll < 69) begin
                queue_frame(FR_FULL_SHORT);
            end else if (roll < 77) begin
                queue_frame(FR_BAD_FORM);
            end else if (roll < 85) begin
                queue_frame(FR_TOO_LONG);
            end else if (roll < 95) begin
                queue_frame(FR_MISMATCH);
            end else begin
                queue_frame(FR_NOISE);
            end
        end
        wait_for_idle();
    endtask

    // Sender: a new byte is put on the bus only once the previous one has been
    // transferred, so valid never falls before its transfer. Gaps come in
    // bursts, each of a length drawn at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            feed_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (feed_gap > 0) begin
                feed_gap--;
                s_valid <= 1'b0;
            end else if (request_bytes.size() != 0 && feed_idle_pct != 0 &&
                         $urandom_range(0, 99) < feed_idle_pct) begin
                feed_gap = $urandom_range(0, 8);
                s_valid <= 1'b0;
            end else if (request_bytes.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= request_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready drops in bursts, each of a length drawn at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: every byte transfer feeds the decoder, and every verdict
    // transfer is checked against the oldest prediction. Signals are read at
    // the edge itself, before any of this edge's updates take effect.
    always @(posedge aclk) begin : verdict_monitor
        arhc_pkg::out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_verdict(s_data);
            end
            if (m_valid && m_ready) begin
                verdict_count++;
                if (pending_verdicts.size() == 0) begin
                    flag_error($sformatf("verdict %0d arrived with none predicted",
                                         verdict_count));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_data.accepted !== want.accepted)
                        flag_error($sformatf("verdict %0d accepted %0d, expected %0d",
                                             verdict_count, m_data.accepted, want.accepted));
                    if (m_data.status !== want.status)
                        flag_error($sformatf("verdict %0d status %0d, expected %0d",
                                             verdict_count, m_data.status, want.status));
                    if (m_data.session_id !== want.session_id)
                        flag_error($sformatf("verdict %0d session_id %h, expected %h",
                                             verdict_count, m_data.session_id,
                                             want.session_id));
                    if (m_data.message_type !== want.message_type)
                        flag_error($sformatf("verdict %0d message_type %h, expected %h",
                                             verdict_count, m_data.message_type,
                                             want.message_type));
                    if (m_data.peer_mask !== want.peer_mask)
                        flag_error($sformatf("verdict %0d peer_mask %h, expected %h",
                                             verdict_count, m_data.peer_mask,
                                             want.peer_mask));
                    if (m_data.has_mask !== want.has_mask)
                        flag_error($sformatf("verdict %0d has_mask %0d, expected %0d",
                                             verdict_count, m_data.has_mask, want.has_mask));
                    if (m_data.payload_length !== want.payload_length)
                        flag_error($sformatf("verdict %0d payload_length %h, expected %h",
                                             verdict_count, m_data.payload_length,
                                             want.payload_length));
                    if (m_data.payload_offset !== want.payload_offset)
                        flag_error($sformatf("verdict %0d payload_offset %0d, expected %0d",
                                             verdict_count, m_data.payload_offset,
                                             want.payload_offset));
                end
            end
        end
    end

    // Main sequence: reset, a few directed frames, then phases of random
    // frames under different register settings and idling patterns.
    initial begin : stimulus
        arhc_pkg::in_item_t lone;
        arhc_pkg::cfg_t     next_cfg;
        logic [7:0]         shared_code;

        active_cfg.full_form_code    = arhc_pkg::FULL_FORM_CODE_RESET;
        active_cfg.compact_form_code = arhc_pkg::COMPACT_FORM_CODE_RESET;
        active_cfg.max_payload_bytes = arhc_pkg::MAX_PAYLOAD_BYTES_RESET;
        seen_bytes  = 0;
        cap_session = '0;
        cap_form    = '0;
        cap_type    = '0;
        cap_length  = '0;
        cap_mask    = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset settings: a frame of a single byte,
        // which is the shortest possible, and then a well-formed compact one.
        lone.data_byte    = 8'hFF;
        lone.end_of_frame = 1'b1;
        request_bytes.push_back(lone);
        queued_bytes++;
        queue_frame(FR_COMPACT_OK);
        wait_for_idle();

        // Reset settings, light idling on both sides.
        feed_idle_pct = 10;
        stall_pct     = 10;
        run_frames(280);

        // Codes at the extremes and a zero limit: only empty payloads pass.
        next_cfg = '{full_form_code: 8'd0, compact_form_code: 8'd255,
                     max_payload_bytes: 32'd0};
        apply_config(next_cfg);
        feed_idle_pct = 25;
        stall_pct     = 0;
        run_frames(280);

        // Swapped extreme codes and no limit at all. The sender stops halfway
        // and lets every outstanding verdict come back before going on.
        next_cfg = '{full_form_code: 8'd255, compact_form_code: 8'd0,
                     max_payload_bytes: 32'hFFFF_FFFF};
        apply_config(next_cfg);
        feed_idle_pct = 0;
        stall_pct     = 25;
        run_frames(140);
        run_frames(140);

        // Both forms share one code, so every match is taken as full form.
        shared_code = 8'($urandom_range(0, 255));
        next_cfg = '{full_form_code: shared_code, compact_form_code: shared_code,
                     max_payload_bytes: $urandom_range(0, 64)};
        apply_config(next_cfg);
        feed_idle_pct = 30;
        stall_pct     = 30;
        run_frames(280);

        // Random codes with a small limit, so both sides of it come up often.
        next_cfg.full_form_code = 8'($urandom_range(0, 255));
        do begin
            next_cfg.compact_form_code = 8'($urandom_range(0, 255));
        end while (next_cfg.compact_form_code == next_cfg.full_form_code);
        next_cfg.max_payload_bytes = $urandom_range(0, 100);
        apply_config(next_cfg);
        feed_idle_pct = 15;
        stall_pct     = 15;
        run_frames(280);

        // Back to the reset values, at full rate with no idling at all.
        next_cfg = '{full_form_code: arhc_pkg::FULL_FORM_CODE_RESET,
                     compact_form_code: arhc_pkg::COMPACT_FORM_CODE_RESET,
                     max_payload_bytes: arhc_pkg::MAX_PAYLOAD_BYTES_RESET};
        apply_config(next_cfg);
        feed_idle_pct = 0;
        stall_pct     = 0;
        run_frames(250);

        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // A hung handshake would otherwise stall the run forever.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
